/* rtl/xxhash32_engine_unit_macros.svh */
// Assertion macros shared by the xxHash32 engine modules.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef XXHASH32_ENGINE_UNIT_MACROS_SVH
`define XXHASH32_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XXH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/xxh32_pkg.sv */
`timescale 1ns / 1ps

package xxh32_pkg;

  // Published xxHash32 primes.
  localparam logic [31:0] PRIME1 = 32'h9E3779B1;
  localparam logic [31:0] PRIME2 = 32'h85EBCA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
  localparam logic [31:0] PRIME5 = 32'h165667B1;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_LM1,
    ST_LADD,
    ST_LM2,
    ST_MRG1,
    ST_MRG2,
    ST_MRG3,
    ST_TWM1,
    ST_TWADD,
    ST_TWM2,
    ST_TBM1,
    ST_TBADD,
    ST_TBM2,
    ST_AV1,
    ST_AVM1,
    ST_AV2,
    ST_AVM2,
    ST_FINAL
  } state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_LANE_INIT,
    CMD_LANE_MUL1,
    CMD_LANE_ADD,
    CMD_LANE_MUL2,
    CMD_MERGE1,
    CMD_MERGE2,
    CMD_MERGE3,
    CMD_TW_MUL1,
    CMD_TW_ADD,
    CMD_TW_MUL2,
    CMD_TB_MUL1,
    CMD_TB_ADD,
    CMD_TB_MUL2,
    CMD_AV_XOR15,
    CMD_AV_MUL2,
    CMD_AV_XOR13,
    CMD_AV_MUL3,
    CMD_FINAL
  } op_t;

  // Command from controller to datapath.
  typedef struct packed {
    op_t        op;
    logic [1:0] idx;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic       push_full;
    logic       in_last;
    logic       last;
    logic [2:0] stripe_cnt;
    logic [2:0] tail_cnt;
  } status_t;

  // Rotate left by a constant amount.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
    rotl32 = (v << r) | (v >> (32 - r));
  endfunction

endpackage

/* rtl/xxh32_dp.sv */
`timescale 1ns / 1ps

`include "xxhash32_engine_unit_macros.svh"

module xxh32_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_seed,
  input  logic [31:0]        in_data_word,
  input  logic [2:0]         in_byte_count,
  input  logic               in_last_word,
  input  xxh32_pkg::cmd_t    cmd,
  output xxh32_pkg::status_t status,
  output logic [31:0]        out_hash_value
);

  logic [31:0] seed_r, seed_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0]  stripe_cnt_r, stripe_cnt_nxt;
  logic        seen_r, seen_nxt;

  logic [31:0] lane_r [4];
  logic [31:0] stripe_r [4];
  logic [31:0] word_r;
  logic [2:0]  tail_cnt_r;
  logic        last_r;
  logic [31:0] mul_r;
  logic [31:0] tmp_r;
  logic [31:0] h_r;
  logic [31:0] hash_r;

  logic [2:0]  eff_cnt;
  logic [7:0]  tail_byte;
  logic [31:0] mul_a, mul_b, mul_lo;
  logic [31:0] rl0, rl1, rl2, rl3;

  // Effective byte count: inner words and oversize counts are full words.
  assign eff_cnt = (!in_last_word || in_byte_count > 3'd4) ? 3'd4 : in_byte_count;

  // Tail byte picked by the loop index.
  always_comb begin
    case (cmd.idx)
      2'd0:    tail_byte = word_r[7:0];
      2'd1:    tail_byte = word_r[15:8];
      2'd2:    tail_byte = word_r[23:16];
      default: tail_byte = word_r[31:24];
    endcase
  end

  // Lane rotations for the merge.
  assign rl0 = xxh32_pkg::rotl32(lane_r[0], 1);
  assign rl1 = xxh32_pkg::rotl32(lane_r[1], 7);
  assign rl2 = xxh32_pkg::rotl32(lane_r[2], 12);
  assign rl3 = xxh32_pkg::rotl32(lane_r[3], 18);

  // Operand selection for the one shared multiplier (low 32 bits kept).
  always_comb begin
    mul_a = h_r;
    mul_b = xxh32_pkg::PRIME1;
    case (cmd.op)
      xxh32_pkg::CMD_LANE_MUL1: begin
        mul_a = stripe_r[cmd.idx];
        mul_b = xxh32_pkg::PRIME2;
      end
      xxh32_pkg::CMD_LANE_MUL2: begin
        mul_a = tmp_r;
        mul_b = xxh32_pkg::PRIME1;
      end
      xxh32_pkg::CMD_TW_MUL1: begin
        mul_a = stripe_r[cmd.idx];
        mul_b = xxh32_pkg::PRIME3;
      end
      xxh32_pkg::CMD_TW_MUL2: mul_b = xxh32_pkg::PRIME4;
      xxh32_pkg::CMD_TB_MUL1: begin
        mul_a = {24'd0, tail_byte};
        mul_b = xxh32_pkg::PRIME5;
      end
      xxh32_pkg::CMD_TB_MUL2: mul_b = xxh32_pkg::PRIME1;
      xxh32_pkg::CMD_AV_MUL2: mul_b = xxh32_pkg::PRIME2;
      xxh32_pkg::CMD_AV_MUL3: mul_b = xxh32_pkg::PRIME3;
      default: ;
    endcase
  end

  assign mul_lo = mul_a * mul_b;

  // Next values of the message control state.
  always_comb begin
    seed_nxt       = seed_r;
    len_nxt        = len_r;
    stripe_cnt_nxt = stripe_cnt_r;
    seen_nxt       = seen_r;
    if (cfg_valid && cfg_ready) begin
      seed_nxt = cfg_seed;
    end
    case (cmd.op)
      xxh32_pkg::CMD_ACCEPT: begin
        len_nxt = len_r + {29'd0, eff_cnt};
        if (eff_cnt == 3'd4) begin
          stripe_cnt_nxt = stripe_cnt_r + 3'd1;
        end
      end
      xxh32_pkg::CMD_LANE_INIT: seen_nxt = 1'b1;
      xxh32_pkg::CMD_LANE_MUL2: begin
        if (cmd.idx == 2'd3) begin
          stripe_cnt_nxt = 3'd0;
        end
      end
      xxh32_pkg::CMD_FINAL: begin
        len_nxt        = 32'd0;
        stripe_cnt_nxt = 3'd0;
        seen_nxt       = 1'b0;
      end
      default: ;
    endcase
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= 32'd0;
      len_r        <= 32'd0;
      stripe_cnt_r <= 3'd0;
      seen_r       <= 1'b0;
    end else begin
      seed_r       <= seed_nxt;
      len_r        <= len_nxt;
      stripe_cnt_r <= stripe_cnt_nxt;
      seen_r       <= seen_nxt;
    end
  end

  // Payload registers, updated by the current operation.
  always_ff @(posedge clk) begin
    case (cmd.op)
      xxh32_pkg::CMD_ACCEPT: begin
        word_r     <= in_data_word;
        tail_cnt_r <= eff_cnt;
        last_r     <= in_last_word;
        if (eff_cnt == 3'd4) begin
          stripe_r[stripe_cnt_r[1:0]] <= in_data_word;
        end
      end
      xxh32_pkg::CMD_LANE_INIT: begin
        if (!seen_r) begin
          lane_r[0] <= seed_r + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
          lane_r[1] <= seed_r + xxh32_pkg::PRIME2;
          lane_r[2] <= seed_r;
          lane_r[3] <= seed_r - xxh32_pkg::PRIME1;
        end
      end
      xxh32_pkg::CMD_LANE_MUL1: mul_r <= mul_lo;
      xxh32_pkg::CMD_LANE_ADD:  tmp_r <= xxh32_pkg::rotl32(lane_r[cmd.idx] + mul_r, 13);
      xxh32_pkg::CMD_LANE_MUL2: lane_r[cmd.idx] <= mul_lo;
      xxh32_pkg::CMD_MERGE1:    h_r <= seen_r ? rl0 + rl1 : seed_r + xxh32_pkg::PRIME5;
      xxh32_pkg::CMD_MERGE2:    h_r <= h_r + len_r;
      xxh32_pkg::CMD_MERGE3:    h_r <= seen_r ? h_r + rl2 + rl3 : h_r;
      xxh32_pkg::CMD_TW_MUL1:   mul_r <= mul_lo;
      xxh32_pkg::CMD_TW_ADD:    h_r <= xxh32_pkg::rotl32(h_r + mul_r, 17);
      xxh32_pkg::CMD_TW_MUL2:   h_r <= mul_lo;
      xxh32_pkg::CMD_TB_MUL1:   mul_r <= mul_lo;
      xxh32_pkg::CMD_TB_ADD:    h_r <= xxh32_pkg::rotl32(h_r + mul_r, 11);
      xxh32_pkg::CMD_TB_MUL2:   h_r <= mul_lo;
      xxh32_pkg::CMD_AV_XOR15:  h_r <= h_r ^ (h_r >> 15);
      xxh32_pkg::CMD_AV_MUL2:   h_r <= mul_lo;
      xxh32_pkg::CMD_AV_XOR13:  h_r <= h_r ^ (h_r >> 13);
      xxh32_pkg::CMD_AV_MUL3:   h_r <= mul_lo;
      xxh32_pkg::CMD_FINAL:     hash_r <= h_r ^ (h_r >> 16);
      default: ;
    endcase
  end

  // Status back to the controller.
  assign status.push_full  = (eff_cnt == 3'd4) && (stripe_cnt_r == 3'd3);
  assign status.in_last    = in_last_word;
  assign status.last       = last_r;
  assign status.stripe_cnt = stripe_cnt_r;
  assign status.tail_cnt   = tail_cnt_r;

  assign out_hash_value = hash_r;

  `XXH_ASSERT_SAME(a_stripe_cnt_range, 1'b1, stripe_cnt_r <= 3'd4, "stripe count out of range")
  `XXH_ASSERT_NEXT(a_full_after_push, (cmd.op == xxh32_pkg::CMD_ACCEPT) && status.push_full, stripe_cnt_r == 3'd4, "stripe buffer not full after fourth word")

endmodule

/* rtl/xxh32_ctrl.sv */
`timescale 1ns / 1ps

`include "xxhash32_engine_unit_macros.svh"

module xxh32_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  xxh32_pkg::status_t status,
  output xxh32_pkg::cmd_t    cmd
);

  xxh32_pkg::state_t state_r, state_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              byte_tail;
  logic [2:0]        idx_inc;

  // The last word carries bytes to fold when its count is one to three.
  assign byte_tail = (status.tail_cnt != 3'd0) && (status.tail_cnt < 3'd4);
  assign idx_inc   = {1'b0, idx_r} + 3'd1;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xxh32_pkg::ST_IDLE;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = xxh32_pkg::CMD_NONE;
    cmd.idx       = idx_r;
    unique case (state_r)
      xxh32_pkg::ST_IDLE: begin
        idx_nxt = 2'd0;
        if (in_valid) begin
          cmd.op = xxh32_pkg::CMD_ACCEPT;
          if (status.push_full) begin
            state_nxt = xxh32_pkg::ST_INIT;
          end else if (status.in_last) begin
            state_nxt = xxh32_pkg::ST_MRG1;
          end
        end
      end
      xxh32_pkg::ST_INIT: begin
        cmd.op    = xxh32_pkg::CMD_LANE_INIT;
        idx_nxt   = 2'd0;
        state_nxt = xxh32_pkg::ST_LM1;
      end
      xxh32_pkg::ST_LM1: begin
        cmd.op    = xxh32_pkg::CMD_LANE_MUL1;
        state_nxt = xxh32_pkg::ST_LADD;
      end
      xxh32_pkg::ST_LADD: begin
        cmd.op    = xxh32_pkg::CMD_LANE_ADD;
        state_nxt = xxh32_pkg::ST_LM2;
      end
      xxh32_pkg::ST_LM2: begin
        cmd.op = xxh32_pkg::CMD_LANE_MUL2;
        if (idx_r == 2'd3) begin
          idx_nxt   = 2'd0;
          state_nxt = status.last ? xxh32_pkg::ST_MRG1 : xxh32_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_inc[1:0];
          state_nxt = xxh32_pkg::ST_LM1;
        end
      end
      xxh32_pkg::ST_MRG1: begin
        cmd.op    = xxh32_pkg::CMD_MERGE1;
        state_nxt = xxh32_pkg::ST_MRG2;
      end
      xxh32_pkg::ST_MRG2: begin
        cmd.op    = xxh32_pkg::CMD_MERGE2;
        state_nxt = xxh32_pkg::ST_MRG3;
      end
      xxh32_pkg::ST_MRG3: begin
        cmd.op  = xxh32_pkg::CMD_MERGE3;
        idx_nxt = 2'd0;
        if (status.stripe_cnt != 3'd0) begin
          state_nxt = xxh32_pkg::ST_TWM1;
        end else begin
          state_nxt = byte_tail ? xxh32_pkg::ST_TBM1 : xxh32_pkg::ST_AV1;
        end
      end
      xxh32_pkg::ST_TWM1: begin
        cmd.op    = xxh32_pkg::CMD_TW_MUL1;
        state_nxt = xxh32_pkg::ST_TWADD;
      end
      xxh32_pkg::ST_TWADD: begin
        cmd.op    = xxh32_pkg::CMD_TW_ADD;
        state_nxt = xxh32_pkg::ST_TWM2;
      end
      xxh32_pkg::ST_TWM2: begin
        cmd.op = xxh32_pkg::CMD_TW_MUL2;
        if (idx_inc < status.stripe_cnt) begin
          idx_nxt   = idx_inc[1:0];
          state_nxt = xxh32_pkg::ST_TWM1;
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = byte_tail ? xxh32_pkg::ST_TBM1 : xxh32_pkg::ST_AV1;
        end
      end
      xxh32_pkg::ST_TBM1: begin
        cmd.op    = xxh32_pkg::CMD_TB_MUL1;
        state_nxt = xxh32_pkg::ST_TBADD;
      end
      xxh32_pkg::ST_TBADD: begin
        cmd.op    = xxh32_pkg::CMD_TB_ADD;
        state_nxt = xxh32_pkg::ST_TBM2;
      end
      xxh32_pkg::ST_TBM2: begin
        cmd.op = xxh32_pkg::CMD_TB_MUL2;
        if (idx_inc < status.tail_cnt) begin
          idx_nxt   = idx_inc[1:0];
          state_nxt = xxh32_pkg::ST_TBM1;
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = xxh32_pkg::ST_AV1;
        end
      end
      xxh32_pkg::ST_AV1: begin
        cmd.op    = xxh32_pkg::CMD_AV_XOR15;
        state_nxt = xxh32_pkg::ST_AVM1;
      end
      xxh32_pkg::ST_AVM1: begin
        cmd.op    = xxh32_pkg::CMD_AV_MUL2;
        state_nxt = xxh32_pkg::ST_AV2;
      end
      xxh32_pkg::ST_AV2: begin
        cmd.op    = xxh32_pkg::CMD_AV_XOR13;
        state_nxt = xxh32_pkg::ST_AVM2;
      end
      xxh32_pkg::ST_AVM2: begin
        cmd.op    = xxh32_pkg::CMD_AV_MUL3;
        state_nxt = xxh32_pkg::ST_FINAL;
      end
      xxh32_pkg::ST_FINAL: begin
        // Hold the finished hash until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.op        = xxh32_pkg::CMD_FINAL;
          out_valid_nxt = 1'b1;
          idx_nxt       = 2'd0;
          state_nxt     = xxh32_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = xxh32_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == xxh32_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `XXH_ASSERT_NEXT(a_stripe_start, (state_r == xxh32_pkg::ST_IDLE) && in_valid && status.push_full, state_r == xxh32_pkg::ST_INIT, "full stripe did not start lane rounds")
  `XXH_ASSERT_NEXT(a_lane_loop_start, state_r == xxh32_pkg::ST_INIT, (state_r == xxh32_pkg::ST_LM1) && (idx_r == 2'd0), "lane loop did not start at lane zero")
  `XXH_ASSERT_NEXT(a_final_shown, (state_r == xxh32_pkg::ST_FINAL) && (!out_valid_r || out_ready), out_valid_r && (state_r == xxh32_pkg::ST_IDLE), "finished hash not presented")

endmodule

/* rtl/xxhash32_engine_unit.sv */
`timescale 1ns / 1ps

// Streaming xxHash32 engine. Message bytes arrive as little-endian 32-bit
// beats on the in_ channel; in_last_word marks the final beat, whose
// in_byte_count (0 to 4) gives its valid bytes. One hash beat leaves on the
// out_ channel per message. The seed is written on the cfg_ channel, which
// is always ready. Every multiply runs through one shared 32x32 multiplier,
// so each multiply has a state of its own. A word that does not complete
// a 16-byte stripe is just stored. A word that completes a stripe is taken
// in, followed by lane start, then three steps for each of the four lanes.
// The last word adds, on top of that, the merge, three steps for each
// of W leftover whole words (0 to 3) and of B leftover bytes (0 to 3),
// the avalanche and loading the output register. Loading the output
// register waits for as long as an earlier hash is still held by
// out_ready. A new message may be accepted while the previous hash waits
// on out_ready.
module xxhash32_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  xxh32_pkg::cmd_t    cmd;
  xxh32_pkg::status_t status;

  // The seed register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  xxh32_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Lanes, stripe buffer, hash register and multiplier.
  xxh32_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_seed       (cfg_seed),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last_word   (in_last_word),
    .cmd            (cmd),
    .status         (status),
    .out_hash_value (out_hash_value)
  );

endmodule
